// ----- src/wtc_pkg.sv -----
// shared types, codes and the contraction stem table for the word tokenizer
// no dependencies
package wtc_pkg;

  // byte class decided by the front end
  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_APOS  = 2'd1,
    OP_DELIM = 2'd2
  } op_e;

  localparam int STEM_DEPTH = 6;
  localparam int STEM_COUNT = 23;
  localparam int POS_W      = 32;
  localparam int IDX_W      = 6;
  localparam logic [7:0] APOSTROPHE = 8'h27;

  // classified word from the front end to the back end
  typedef struct packed {
    op_e              op;
    logic [7:0]       ch;
    logic [POS_W-1:0] pos;
  } front_item_t;

  // one result word
  typedef struct packed {
    logic             kind;
    logic [7:0]       char_out;
    logic [IDX_W-1:0] char_index;
    logic [POS_W-1:0] position;
    logic [IDX_W-1:0] token_length;
    logic             was_truncated;
  } result_t;

  // stem text is right aligned, first character in the highest used byte
  typedef struct packed {
    logic [8*STEM_DEPTH-1:0] text;
    logic [2:0]              len;
  } stem_t;

  localparam stem_t STEMS [STEM_COUNT] = '{
    '{48'("is"), 3'd2},    '{48'("are"), 3'd3},   '{48'("was"), 3'd3},
    '{48'("were"), 3'd4},  '{48'("do"), 3'd2},    '{48'("does"), 3'd4},
    '{48'("did"), 3'd3},   '{48'("ca"), 3'd2},    '{48'("could"), 3'd5},
    '{48'("wo"), 3'd2},    '{48'("would"), 3'd5}, '{48'("should"), 3'd6},
    '{48'("mus"), 3'd3},   '{48'("migh"), 3'd4},  '{48'("need"), 3'd4},
    '{48'("ough"), 3'd4},  '{48'("had"), 3'd3},   '{48'("have"), 3'd4},
    '{48'("has"), 3'd3},   '{48'("dare"), 3'd4},  '{48'("ai"), 3'd2},
    '{48'("may"), 3'd3},   '{48'("sha"), 3'd3}
  };

  // parallel match of the token head against every stem
  function automatic logic stem_hit(input logic [STEM_DEPTH-1:0][7:0] chars,
                                    input logic [2:0] len_clip);
    logic hit;
    logic same;
    int   n;
    hit = 1'b0;
    for (int s = 0; s < STEM_COUNT; s++) begin
      n    = int'(STEMS[s].len);
      same = (len_clip >= STEMS[s].len);
      for (int k = 0; k < STEM_DEPTH; k++) begin
        if (k < n) begin
          if (chars[k] != STEMS[s].text[8*(n-1-k) +: 8]) begin
            same = 1'b0;
          end
        end
      end
      hit = hit | same;
    end
    return hit;
  endfunction

endpackage

// ----- src/wtc_fifo.sv -----
// short register queue used between the tokenizer stages and at the output
// no dependencies
module wtc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- src/wtc_front.sv -----
// front end: byte classification, lowercasing and byte position counter
// depends on wtc_pkg
module wtc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           char_code_i,
  output logic                 valid_o,
  output wtc_pkg::front_item_t item_o
);

  logic [wtc_pkg::POS_W-1:0] pos_q, pos_d;

  // position of the next byte, wraps naturally
  assign pos_d = accept_i ? pos_q + 1'b1 : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // classify the byte
  always_comb begin
    item_o.pos = pos_q;
    item_o.ch  = char_code_i;
    item_o.op  = wtc_pkg::OP_DELIM;
    if (char_code_i >= 8'h41 && char_code_i <= 8'h5a) begin
      item_o.op = wtc_pkg::OP_CHAR;
      item_o.ch = char_code_i + 8'h20;
    end else if ((char_code_i >= 8'h61 && char_code_i <= 8'h7a) ||
                 (char_code_i >= 8'h30 && char_code_i <= 8'h39)) begin
      item_o.op = wtc_pkg::OP_CHAR;
    end else if (char_code_i == wtc_pkg::APOSTROPHE) begin
      item_o.op = wtc_pkg::OP_APOS;
    end
  end

  assign valid_o = accept_i;

endmodule

// ----- src/wtc_back.sv -----
// back end: token state, stem match and result word formation
// depends on wtc_pkg
module wtc_back #(
  parameter int MAX_TOKEN_CHARS = 63
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  wtc_pkg::front_item_t item_i,
  output logic                 take_o,
  input  logic                 out_full_i,
  output logic                 res_valid_o,
  output wtc_pkg::result_t     res_o
);

  localparam int LEN_W = $clog2(MAX_TOKEN_CHARS + 1);

  logic [wtc_pkg::STEM_DEPTH-1:0][7:0] stem_q, stem_d;
  logic [LEN_W-1:0]                    len_q, len_d;
  logic                                ovf_q, ovf_d;
  logic [2:0]                          len_clip;
  logic [LEN_W+wtc_pkg::IDX_W-1:0]     len_ext;
  logic                                hit;
  logic                                append;

  assign take_o   = valid_i && !out_full_i;
  assign len_clip = (len_q >= LEN_W'(wtc_pkg::STEM_DEPTH)) ?
                    3'(wtc_pkg::STEM_DEPTH) : len_q[2:0];
  assign len_ext  = {{wtc_pkg::IDX_W{1'b0}}, len_q};
  assign hit      = wtc_pkg::stem_hit(stem_q, len_clip);

  // token update and result
  always_comb begin
    stem_d      = stem_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    append      = 1'b0;
    case (item_i.op)
      wtc_pkg::OP_CHAR:  append = 1'b1;
      wtc_pkg::OP_APOS:  append = hit;
      wtc_pkg::OP_DELIM: append = 1'b0;
      default:           append = 1'b0;
    endcase
    if (take_o) begin
      if (append) begin
        if (len_q >= LEN_W'(MAX_TOKEN_CHARS)) begin
          ovf_d = 1'b1;
        end else begin
          if (len_q < LEN_W'(wtc_pkg::STEM_DEPTH)) begin
            stem_d[len_q[2:0]] = item_i.ch;
          end
          len_d            = len_q + 1'b1;
          res_valid_o      = 1'b1;
          res_o.char_out   = item_i.ch;
          res_o.char_index = len_ext[wtc_pkg::IDX_W-1:0];
        end
      end else if (item_i.op == wtc_pkg::OP_DELIM && len_q != '0) begin
        res_valid_o         = 1'b1;
        res_o.kind          = 1'b1;
        res_o.position      = item_i.pos;
        res_o.token_length  = len_ext[wtc_pkg::IDX_W-1:0];
        res_o.was_truncated = ovf_q;
        len_d               = '0;
        ovf_d               = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stem_q <= '0;
      len_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      stem_q <= stem_d;
      len_q  <= len_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

// ----- src/word_tokenizer_with_contractions.sv -----
// top level of the word tokenizer with contraction stems
// depends on wtc_pkg, wtc_front, wtc_fifo and wtc_back
//
// Usage:
//   Input channel is a queue push side: drive char_code_i with one text
//   byte and raise push; the word is taken on a clock edge with push high
//   and full low. Result channel is a queue pop side: while empty is low
//   the oldest result word sits on kind_o .. was_truncated_o, and it is
//   taken on a clock edge with pop high.
//   Each byte yields zero or one result word: a lowercased character, a
//   kept apostrophe, or an end of token word carrying the delimiter
//   position, token length and truncation flag.
//   A taken byte is written into the internal queue; the back end then
//   writes its result word into the output queue, where it can be popped.
//   Throughput: one byte per cycle while full stays low, set by the back
//   end token update and the parallel stem table match.
//   When the receiver stalls, the two-word output queue fills, the back
//   end holds, then the two-word internal queue fills and full rises.
//   Reset clears the byte position, the token and both queues; the first
//   byte after reset has position zero.
module word_tokenizer_with_contractions #(
  parameter int MAX_TOKEN_CHARS = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [7:0]  char_out_o,
  output logic [5:0]  char_index_o,
  output logic [31:0] position_o,
  output logic [5:0]  token_length_o,
  output logic        was_truncated_o
);

  localparam int ITEM_W = $bits(wtc_pkg::front_item_t);
  localparam int RES_W  = $bits(wtc_pkg::result_t);

  logic                 accept;
  logic                 front_valid;
  wtc_pkg::front_item_t front_item;
  logic                 mid_empty;
  logic [ITEM_W-1:0]    mid_data;
  wtc_pkg::front_item_t back_item;
  logic                 back_take;
  logic                 out_full;
  logic                 res_valid;
  wtc_pkg::result_t     res;
  logic [RES_W-1:0]     out_data;
  wtc_pkg::result_t     out_res;

  assign accept = push && !full;

  // classification and position
  wtc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (char_code_i),
    .valid_o     (front_valid),
    .item_o      (front_item)
  );

  // queue between front and back end
  wtc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (2)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .full_o  (full),
    .data_i  (front_item),
    .pop_i   (back_take),
    .empty_o (mid_empty),
    .data_o  (mid_data)
  );

  assign back_item = wtc_pkg::front_item_t'(mid_data);

  // token state and result formation
  wtc_back #(
    .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (!mid_empty),
    .item_i      (back_item),
    .take_o      (back_take),
    .out_full_i  (out_full),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output queue
  wtc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .full_o  (out_full),
    .data_i  (res),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_data)
  );

  assign out_res         = wtc_pkg::result_t'(out_data);
  assign kind_o          = out_res.kind;
  assign char_out_o      = out_res.char_out;
  assign char_index_o    = out_res.char_index;
  assign position_o      = out_res.position;
  assign token_length_o  = out_res.token_length;
  assign was_truncated_o = out_res.was_truncated;

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for word_tokenizer_with_contractions
// feeds text bytes through the push side and checks every popped word against a local tokenizer
// depends on wtc_pkg and the tokenizer rtl
module tb_top;

  localparam int MAX_TOKEN_CHARS = 63;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_BYTES    = 270;
  localparam int STEADY_BYTES    = 60;
  localparam logic KIND_CHAR     = 1'b0;
  localparam logic KIND_END      = 1'b1;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  char_code_i;
  logic        empty;
  logic        pop;
  logic        kind_o;
  logic [7:0]  char_out_o;
  logic [5:0]  char_index_o;
  logic [31:0] position_o;
  logic [5:0]  token_length_o;
  logic        was_truncated_o;

  // contraction stems as the tokenizer knows them
  string contraction_stems [23] = '{
    "is", "are", "was", "were", "do", "does", "did", "ca", "could", "wo",
    "would", "should", "mus", "migh", "need", "ough", "had", "have", "has",
    "dare", "ai", "may", "sha"
  };

  // shadow token state
  logic [7:0]  token_head [wtc_pkg::STEM_DEPTH];
  int          token_len;
  logic        token_overflow;
  logic [31:0] next_position;

  wtc_pkg::result_t pending_words [$];
  bit          idling_on;
  int          errors;
  int          words_checked;
  int          ends_checked;
  int          truncated_ends;
  int          bytes_sent;
  int          cycles;

  word_tokenizer_with_contractions #(
    .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .char_code_i    (char_code_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .char_out_o     (char_out_o),
    .char_index_o   (char_index_o),
    .position_o     (position_o),
    .token_length_o (token_length_o),
    .was_truncated_o(was_truncated_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit is_word_byte(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
  endfunction

  // token head starts with some stem, token at least as long as that stem
  function automatic bit head_has_stem();
    bit same;
    int n;
    for (int s = 0; s < 23; s++) begin
      n    = contraction_stems[s].len();
      same = (token_len >= n);
      for (int k = 0; k < n; k++) begin
        if (token_head[k] != contraction_stems[s][k]) begin
          same = 1'b0;
        end
      end
      if (same) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit append_to_token(input logic [7:0] ch, output wtc_pkg::result_t w);
    w = '0;
    if (token_len >= MAX_TOKEN_CHARS) begin
      token_overflow = 1'b1;
      return 1'b0;
    end
    if (token_len < wtc_pkg::STEM_DEPTH) begin
      token_head[token_len] = ch;
    end
    w.kind       = KIND_CHAR;
    w.char_out   = ch;
    w.char_index = token_len[5:0];
    token_len++;
    return 1'b1;
  endfunction

  // next result word, if any, for one accepted byte
  function automatic bit tokenize_byte(input logic [7:0] c, output wtc_pkg::result_t w);
    logic [31:0] here;
    here          = next_position;
    next_position = here + 32'd1;
    w             = '0;
    if (c >= "A" && c <= "Z") begin
      return append_to_token(c + 8'd32, w);
    end else if (is_word_byte(c)) begin
      return append_to_token(c, w);
    end else if (c == wtc_pkg::APOSTROPHE) begin
      if (head_has_stem()) begin
        return append_to_token(c, w);
      end
      return 1'b0;
    end else if (token_len > 0) begin
      w.kind          = KIND_END;
      w.position      = here;
      w.token_length  = token_len[5:0];
      w.was_truncated = token_overflow;
      token_len       = 0;
      token_overflow  = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one byte through the push side, optionally after a random gap
  task automatic send_byte(input logic [7:0] c);
    wtc_pkg::result_t w;
    @(negedge clk_i);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    push        <= 1'b1;
    char_code_i <= c;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
    if (tokenize_byte(c, w)) begin
      pending_words.push_back(w);
    end
  endtask

  task automatic send_text(input string s, input bit mix_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && c >= "a" && c <= "z" && $urandom_range(0, 1)) begin
        c = c - 8'd32;
      end
      send_byte(c);
    end
  endtask

  function automatic logic [7:0] random_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 26) return 8'("a") + 8'(r);
    if (r < 52) return 8'("A") + 8'(r - 26);
    return 8'("0") + 8'(r - 52);
  endfunction

  function automatic logic [7:0] random_delim();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (is_word_byte(c) || c == wtc_pkg::APOSTROPHE);
    return c;
  endfunction

  task automatic send_alnum_run(input int n);
    for (int i = 0; i < n; i++) begin
      send_byte(random_alnum());
    end
  endtask

  // one random word shape followed by a delimiter
  task automatic send_random_word();
    int    pick;
    string stem;
    pick = $urandom_range(0, 99);
    stem = contraction_stems[$urandom_range(0, 22)];
    if (pick < 50) begin
      // well-formed contraction with a random tail
      send_text(stem, 1'b1);
      send_byte(wtc_pkg::APOSTROPHE);
      send_alnum_run($urandom_range(0, 3));
    end else if (pick < 65) begin
      // stem cut short, the apostrophe is dropped unless a shorter stem still matches
      send_text(stem.substr(0, stem.len() - 2), 1'b1);
      send_byte(wtc_pkg::APOSTROPHE);
      send_alnum_run($urandom_range(0, 2));
    end else if (pick < 82) begin
      // plain word with stray apostrophes
      for (int i = 0; i < $urandom_range(1, 8); i++) begin
        send_byte($urandom_range(0, 4) == 0 ? wtc_pkg::APOSTROPHE : random_alnum());
      end
    end else if (pick < 97) begin
      // raw noise bytes
      for (int i = 0; i < $urandom_range(1, 4); i++) begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end else begin
      // long word near or past the length limit
      send_alnum_run($urandom_range(MAX_TOKEN_CHARS - 3, MAX_TOKEN_CHARS + 6));
    end
    send_byte(random_delim());
  endtask

  // receiver: pop with random stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (idling_on && stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic check_field(input string field, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp, act);
      errors++;
    end
  endtask

  // compare each popped word with the oldest expected one
  always @(posedge clk_i) begin
    wtc_pkg::result_t w;
    if (rst_ni && pop && !empty) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word: kind %0b char 0x%0h", kind_o, char_out_o);
        errors++;
      end else begin
        w = pending_words.pop_front();
        check_field("kind", 32'(w.kind), 32'(kind_o));
        check_field("char_out", 32'(w.char_out), 32'(char_out_o));
        check_field("char_index", 32'(w.char_index), 32'(char_index_o));
        check_field("position", w.position, position_o);
        check_field("token_length", 32'(w.token_length), 32'(token_length_o));
        check_field("was_truncated", 32'(w.was_truncated), 32'(was_truncated_o));
        words_checked++;
        if (w.kind == KIND_END) begin
          ends_checked++;
          if (w.was_truncated) truncated_ends++;
        end
      end
    end
  end

  // character class edges, stale stem bytes, empty-token apostrophe and delimiters
  task automatic test_directed();
    send_text("AZ'@[can c'09`{z/:'", 1'b0);
    send_byte(8'h80);
    send_byte(8'hff);
    send_text("is'", 1'b0);
    send_byte(8'h7f);
  endtask

  // full token: dropped characters and a dropped matching apostrophe
  task automatic test_long_token();
    send_text("Should", 1'b0);
    send_alnum_run(MAX_TOKEN_CHARS - 6);
    send_byte(wtc_pkg::APOSTROPHE);
    send_byte(" ");
    send_alnum_run(MAX_TOKEN_CHARS);
    send_byte(8'h00);
    send_alnum_run(MAX_TOKEN_CHARS + 3);
    send_byte(8'h2e);
  endtask

  task automatic test_random_text();
    int stop_at;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) send_random_word();
  endtask

  // back to back bytes, no idling on either side
  task automatic test_steady_stream();
    int stop_at;
    idling_on = 1'b0;
    stop_at   = bytes_sent + STEADY_BYTES;
    while (bytes_sent < stop_at) send_random_word();
  endtask

  initial begin
    push           = 1'b0;
    pop            = 1'b0;
    char_code_i    = '0;
    rst_ni         = 1'b0;
    idling_on      = 1'b1;
    errors         = 0;
    cycles         = 0;
    bytes_sent     = 0;
    token_len      = 0;
    token_overflow = 1'b0;
    next_position  = '0;
    foreach (token_head[k]) token_head[k] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_long_token();
    test_random_text();
    test_steady_stream();

    @(negedge clk_i);
    push <= 1'b0;
    while (pending_words.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d bytes, %0d result words checked", bytes_sent, words_checked);
    $display("%0d token ends seen, %0d of them truncated", ends_checked, truncated_ends);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
